@@ rtl/core/smix_pkg.sv @@
// Shared types, constants and microcode table for the stereo mixer and output filter.
package smix_pkg;

    localparam int CHANNELS           = 4;
    localparam int STATE_FRAC_DEFAULT = 16;
    localparam int STATE_FRAC_MIN     = 8;
    localparam int STATE_FRAC_MAX     = 24;
    localparam int SAMPLE_W           = 8;
    localparam int VOLUME_W           = 6;
    localparam int OUT_W              = 16;
    localparam int COEF_W             = 17;
    localparam int COEF_FRAC          = 16;
    localparam int MIX_SHIFT          = 16 - 14 - 1;
    localparam int POLES_PER_SIDE     = 5;
    localparam int NUM_POLES          = 2 * POLES_PER_SIDE;
    localparam int POLE_AW            = $clog2(NUM_POLES);
    localparam int FIELD_AW           = $clog2(POLES_PER_SIDE);
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 17;
    localparam int PROG_LEN           = 21;
    localparam int STEP_W             = $clog2(PROG_LEN);

    localparam logic [COEF_W-1:0] COEF_UNITY = COEF_W'(65536);
    localparam logic signed [OUT_W:0] SAT_MAX = 17'sd32767;
    localparam logic signed [OUT_W:0] SAT_MIN = -17'sd32768;

    localparam logic [1:0] MODEL_OFF    = 2'd0;
    localparam logic [1:0] MODEL_RC_LED = 2'd1;
    localparam logic [1:0] MODEL_LED    = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FILTER_MODEL = 3'd0,
        CFG_LED_ON       = 3'd1,
        CFG_COEF_ONE     = 3'd2,
        CFG_COEF_TWO     = 3'd3,
        CFG_COEF_LED     = 3'd4,
        CFG_CHAN_EN      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_zero;
        logic signed [SAMPLE_W-1:0] sample_one;
        logic signed [SAMPLE_W-1:0] sample_two;
        logic signed [SAMPLE_W-1:0] sample_three;
        logic [VOLUME_W-1:0]        volume_zero;
        logic [VOLUME_W-1:0]        volume_one;
        logic [VOLUME_W-1:0]        volume_two;
        logic [VOLUME_W-1:0]        volume_three;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] left_out;
        logic signed [OUT_W-1:0] right_out;
    } out_item_t;

    typedef struct packed {
        logic [1:0]          filter_model;
        logic                led_on;
        logic [COEF_W-1:0]   coef_stage_one;
        logic [COEF_W-1:0]   coef_stage_two;
        logic [COEF_W-1:0]   coef_led;
        logic [CHANNELS-1:0] channel_enable;
    } cfg_t;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_JUMP,
        OP_MUL,
        OP_UPD,
        OP_OUT
    } op_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_OFF,
        COND_LED_ONLY
    } cond_t;

    typedef enum logic [1:0] {
        COEF_RC1,
        COEF_RC2,
        COEF_LED
    } coef_sel_t;

    typedef struct packed {
        op_t                 op;
        cond_t               cond;
        logic [FIELD_AW-1:0] field;
        coef_sel_t           coef_sel;
        logic                norm_we;
        logic [STEP_W-1:0]   target;
    } uop_t;

    typedef struct packed {
        logic               run;
        op_t                op;
        logic [POLE_AW-1:0] addr;
        coef_sel_t          coef_sel;
        logic               norm_we;
        logic               side;
    } ctrl_t;

    function automatic uop_t mk(op_t op, cond_t cond, int field, coef_sel_t cs,
                                logic nw, int target);
        uop_t u;
        u.op       = op;
        u.cond     = cond;
        u.field    = FIELD_AW'(field);
        u.coef_sel = cs;
        u.norm_we  = nw;
        u.target   = STEP_W'(target);
        return u;
    endfunction

    // Per-side program; OUT on the left side loops back to step 0 for the right side.
    function automatic uop_t ucode(logic [STEP_W-1:0] step);
        uop_t u;
        unique case (step)
            5'd0:    u = mk(OP_LOAD, COND_ALWAYS,   0, COEF_LED, 1'b0, 0);
            5'd1:    u = mk(OP_JUMP, COND_OFF,      0, COEF_LED, 1'b0, 20);
            5'd2:    u = mk(OP_JUMP, COND_LED_ONLY, 0, COEF_LED, 1'b0, 14);
            5'd3:    u = mk(OP_MUL,  COND_ALWAYS,   0, COEF_RC1, 1'b0, 0);
            5'd4:    u = mk(OP_UPD,  COND_ALWAYS,   0, COEF_RC1, 1'b0, 0);
            5'd5:    u = mk(OP_MUL,  COND_ALWAYS,   1, COEF_RC2, 1'b0, 0);
            5'd6:    u = mk(OP_UPD,  COND_ALWAYS,   1, COEF_RC2, 1'b1, 0);
            5'd7:    u = mk(OP_MUL,  COND_ALWAYS,   2, COEF_LED, 1'b0, 0);
            5'd8:    u = mk(OP_UPD,  COND_ALWAYS,   2, COEF_LED, 1'b0, 0);
            5'd9:    u = mk(OP_MUL,  COND_ALWAYS,   3, COEF_LED, 1'b0, 0);
            5'd10:   u = mk(OP_UPD,  COND_ALWAYS,   3, COEF_LED, 1'b0, 0);
            5'd11:   u = mk(OP_MUL,  COND_ALWAYS,   4, COEF_LED, 1'b0, 0);
            5'd12:   u = mk(OP_UPD,  COND_ALWAYS,   4, COEF_LED, 1'b0, 0);
            5'd13:   u = mk(OP_JUMP, COND_ALWAYS,   0, COEF_LED, 1'b0, 20);
            5'd14:   u = mk(OP_MUL,  COND_ALWAYS,   1, COEF_LED, 1'b0, 0);
            5'd15:   u = mk(OP_UPD,  COND_ALWAYS,   1, COEF_LED, 1'b0, 0);
            5'd16:   u = mk(OP_MUL,  COND_ALWAYS,   2, COEF_LED, 1'b0, 0);
            5'd17:   u = mk(OP_UPD,  COND_ALWAYS,   2, COEF_LED, 1'b0, 0);
            5'd18:   u = mk(OP_MUL,  COND_ALWAYS,   3, COEF_LED, 1'b0, 0);
            5'd19:   u = mk(OP_UPD,  COND_ALWAYS,   3, COEF_LED, 1'b0, 0);
            5'd20:   u = mk(OP_OUT,  COND_ALWAYS,   0, COEF_LED, 1'b0, 0);
            default: u = mk(OP_JUMP, COND_ALWAYS,   0, COEF_LED, 1'b0, 20);
        endcase
        return u;
    endfunction

endpackage

@@ rtl/core/smix_mixer.sv @@
// Volume scaling, channel muting and left/right mixing of one input transaction.
module smix_mixer (
    input  logic                    clk,
    input  logic                    load,
    input  smix_pkg::in_item_t      item,
    input  logic [3:0]              channel_enable,
    output logic signed [15:0]      mix_left,
    output logic signed [15:0]      mix_right
);
    import smix_pkg::*;

    logic signed [SAMPLE_W-1:0]        smp  [CHANNELS];
    logic [VOLUME_W-1:0]               vol  [CHANNELS];
    logic signed [SAMPLE_W+VOLUME_W:0] prod [CHANNELS];
    logic signed [OUT_W:0]             sum_l;
    logic signed [OUT_W:0]             sum_r;
    logic signed [OUT_W-1:0]           mix_l_reg, mix_l_next;
    logic signed [OUT_W-1:0]           mix_r_reg, mix_r_next;

    always_comb
    begin
        smp[0] = item.sample_zero;
        smp[1] = item.sample_one;
        smp[2] = item.sample_two;
        smp[3] = item.sample_three;
        vol[0] = item.volume_zero;
        vol[1] = item.volume_one;
        vol[2] = item.volume_two;
        vol[3] = item.volume_three;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (channel_enable[i])
                prod[i] = smp[i] * $signed({1'b0, vol[i]});
            else
                prod[i] = '0;
        end
        sum_l      = (OUT_W+1)'(prod[0]) + (OUT_W+1)'(prod[3]);
        sum_r      = (OUT_W+1)'(prod[1]) + (OUT_W+1)'(prod[2]);
        mix_l_next = OUT_W'(sum_l <<< MIX_SHIFT);
        mix_r_next = OUT_W'(sum_r <<< MIX_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mix_l_reg <= mix_l_next;
            mix_r_reg <= mix_r_next;
        end
    end

    assign mix_left  = mix_l_reg;
    assign mix_right = mix_r_reg;

endmodule

@@ rtl/core/smix_sequencer.sv @@
// Microcode sequencer: step counter, control table lookup and conditional jumps.
module smix_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             stall,
    input  logic [1:0]       filter_model,
    output smix_pkg::ctrl_t  ctrl,
    output logic             done
);
    import smix_pkg::*;

    logic              run_reg, run_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              side_reg, side_next;
    uop_t              uop;
    logic              cond_true;

    assign uop = ucode(step_reg);

    always_comb
    begin
        unique case (uop.cond)
            COND_ALWAYS:   cond_true = 1'b1;
            COND_OFF:      cond_true = (filter_model != MODEL_RC_LED) &&
                                       (filter_model != MODEL_LED);
            COND_LED_ONLY: cond_true = (filter_model == MODEL_LED);
            default:       cond_true = 1'b0;
        endcase
    end

    assign done = run_reg && (uop.op == OP_OUT) && side_reg && !stall;

    always_comb
    begin
        run_next  = run_reg;
        step_next = step_reg;
        side_next = side_reg;
        if (!run_reg)
        begin
            if (start)
            begin
                run_next  = 1'b1;
                step_next = '0;
                side_next = 1'b0;
            end
        end
        else
        begin
            unique case (uop.op)
                OP_JUMP:
                begin
                    step_next = cond_true ? uop.target : step_reg + 1'b1;
                end
                OP_OUT:
                begin
                    if (!side_reg)
                    begin
                        side_next = 1'b1;
                        step_next = uop.target;
                    end
                    else if (!stall)
                    begin
                        run_next = 1'b0;
                    end
                end
                default:
                begin
                    step_next = step_reg + 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
            side_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            step_reg <= step_next;
            side_reg <= side_next;
        end
    end

    always_comb
    begin
        ctrl.run      = run_reg;
        ctrl.op       = uop.op;
        ctrl.addr     = side_reg ? POLE_AW'(uop.field) + POLE_AW'(POLES_PER_SIDE)
                                 : POLE_AW'(uop.field);
        ctrl.coef_sel = uop.coef_sel;
        ctrl.norm_we  = uop.norm_we;
        ctrl.side     = side_reg;
    end

endmodule

@@ rtl/core/smix_datapath.sv @@
// Filter datapath: pole state registers, shared pole multiplier, output truncation and clamp.
module smix_datapath #(
    parameter int STATE_FRACTION_BITS = smix_pkg::STATE_FRAC_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  smix_pkg::ctrl_t      ctrl,
    input  smix_pkg::cfg_t       cfg,
    input  logic signed [15:0]   mix_left,
    input  logic signed [15:0]   mix_right,
    output smix_pkg::out_item_t  result
);
    import smix_pkg::*;

    localparam int SW = OUT_W + STATE_FRACTION_BITS;
    localparam int PW = SW + COEF_W + 2;

    logic signed [SW-1:0] pole_reg [NUM_POLES];
    logic signed [SW-1:0] acc_reg;
    logic signed [SW-1:0] norm_reg;
    logic signed [SW-1:0] y_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [OUT_W-1:0] left_res_reg;

    logic [COEF_W-1:0]    coef_raw;
    logic [COEF_W-1:0]    coef_sat;
    logic signed [SW-1:0] x_in;
    logic signed [SW-1:0] y_cur;
    logic signed [SW:0]   diff;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] prod_sh;
    logic signed [PW-1:0] upd_sum;
    logic signed [SW-1:0] upd_val;
    logic signed [SW-1:0] sel;
    logic [SW:0]          bias;
    logic [SW:0]          rnd;
    logic signed [OUT_W:0] q;
    logic signed [OUT_W-1:0] sat_val;

    always_comb
    begin
        unique case (ctrl.coef_sel)
            COEF_RC1: coef_raw = cfg.coef_stage_one;
            COEF_RC2: coef_raw = cfg.coef_stage_two;
            COEF_LED: coef_raw = cfg.coef_led;
            default:  coef_raw = cfg.coef_led;
        endcase
        coef_sat = coef_raw[COEF_W-1] ? COEF_UNITY : coef_raw;
    end

    // y' = y + floor(a * (x - y) / 2^16)
    assign x_in      = {(ctrl.side ? mix_right : mix_left), {STATE_FRACTION_BITS{1'b0}}};
    assign y_cur     = pole_reg[ctrl.addr];
    assign diff      = (SW+1)'(acc_reg) - (SW+1)'(y_cur);
    assign prod_next = PW'($signed({1'b0, coef_sat}) * diff);
    assign prod_sh   = prod_reg >>> COEF_FRAC;
    assign upd_sum   = PW'(y_reg) + prod_sh;
    assign upd_val   = upd_sum[SW-1:0];

    // truncate toward zero, then clamp
    assign sel  = cfg.led_on ? acc_reg : norm_reg;
    assign bias = sel[SW-1] ? (SW+1)'({STATE_FRACTION_BITS{1'b1}}) : '0;
    assign rnd  = {sel[SW-1], sel} + bias;
    assign q    = $signed(rnd[SW:STATE_FRACTION_BITS]);

    always_comb
    begin
        priority if (q > SAT_MAX)
            sat_val = OUT_W'(SAT_MAX);
        else if (q < SAT_MIN)
            sat_val = OUT_W'(SAT_MIN);
        else
            sat_val = q[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_POLES; i++)
            begin
                pole_reg[i] <= '0;
            end
        end
        else if (ctrl.run && ctrl.op == OP_UPD)
        begin
            pole_reg[ctrl.addr] <= upd_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.run)
        begin
            unique case (ctrl.op)
                OP_LOAD:
                begin
                    acc_reg  <= x_in;
                    norm_reg <= x_in;
                end
                OP_MUL:
                begin
                    prod_reg <= prod_next;
                    y_reg    <= y_cur;
                end
                OP_UPD:
                begin
                    acc_reg <= upd_val;
                    if (ctrl.norm_we)
                    begin
                        norm_reg <= upd_val;
                    end
                end
                OP_OUT:
                begin
                    if (!ctrl.side)
                    begin
                        left_res_reg <= sat_val;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result.left_out  = left_res_reg;
    assign result.right_out = sat_val;

endmodule

@@ rtl/core/stereo_mix_rc_led_filter.sv @@
// Top level: four-channel stereo mixer with RC and LED output filter models.
//
//  Channel  Handshake             Payload
//  -------  --------------------  --------------------------------------
//  in       in_valid / in_ready   in_data   (four samples, four volumes)
//  out      out_valid / out_ready out_data  (left_out, right_out)
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  A transaction runs the microcode for the left side, then the right side,
//  with both RC stages and LED poles, with LED poles only or with filtering
//  off; in_ready returns as the result is registered. The shared pole
//  multiplier runs two microcode steps per pole, both sides in turn.
//  in_ready drops while the sequencer runs; a result waiting in the output
//  register does not block the next accept, only the final step of the next one.
//  Reset clears all pole state and loads register defaults; no clearing pass.
//  cfg_ready is always high.
module stereo_mix_rc_led_filter #(
    parameter int STATE_FRACTION_BITS = smix_pkg::STATE_FRAC_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  smix_pkg::in_item_t                     in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output smix_pkg::out_item_t                    out_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [smix_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [smix_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import smix_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;
    ctrl_t     ctrl;
    logic      done;
    logic      stall;
    logic      start;
    logic signed [OUT_W-1:0] mix_left;
    logic signed [OUT_W-1:0] mix_right;
    out_item_t result;

    assign cfg_ready = 1'b1;
    assign in_ready  = !ctrl.run;
    assign start     = in_valid && in_ready;
    assign stall     = out_valid_reg && !out_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FILTER_MODEL: cfg_next.filter_model   = cfg_data[1:0];
                CFG_LED_ON:       cfg_next.led_on         = cfg_data[0];
                CFG_COEF_ONE:     cfg_next.coef_stage_one = cfg_data[COEF_W-1:0];
                CFG_COEF_TWO:     cfg_next.coef_stage_two = cfg_data[COEF_W-1:0];
                CFG_COEF_LED:     cfg_next.coef_led       = cfg_data[COEF_W-1:0];
                CFG_CHAN_EN:      cfg_next.channel_enable = cfg_data[CHANNELS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_model   <= MODEL_RC_LED;
            cfg_reg.led_on         <= 1'b0;
            cfg_reg.coef_stage_one <= COEF_UNITY;
            cfg_reg.coef_stage_two <= COEF_UNITY;
            cfg_reg.coef_led       <= COEF_UNITY;
            cfg_reg.channel_enable <= '1;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    smix_mixer u_mixer (
        .clk            (clk),
        .load           (start),
        .item           (in_data),
        .channel_enable (cfg_reg.channel_enable),
        .mix_left       (mix_left),
        .mix_right      (mix_right)
    );

    smix_sequencer u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .stall        (stall),
        .filter_model (cfg_reg.filter_model),
        .ctrl         (ctrl),
        .done         (done)
    );

    smix_datapath #(
        .STATE_FRACTION_BITS (STATE_FRACTION_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cfg       (cfg_reg),
        .mix_left  (mix_left),
        .mix_right (mix_right),
        .result    (result)
    );

endmodule

@@ rtl/core/smix_checker.sv @@
// Port-level assertions for the stereo mixer filter, bound to the top level.
module smix_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input smix_pkg::out_item_t  out_data,
    input logic                 cfg_ready
);
    import smix_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a transaction is in progress");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a transaction in progress");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after accept");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind stereo_mix_rc_led_filter smix_checker u_smix_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_ready (cfg_ready)
);
